FILE: design/bcs_pkg.sv
package bcs_pkg;

   // Field widths of the channel.
   localparam int NS_W  = 16;
   localparam int AMP_W = 8;
   localparam int HPC_W = 18;
   localparam int TOG_W = 32;

   // Item kinds.
   localparam logic KIND_ADVANCE = 1'b0;
   localparam logic KIND_LEVEL   = 1'b1;

   // Register indexes of the configuration port.
   localparam logic REG_PERIOD_HIGH = 1'b0;
   localparam logic REG_PERIOD_LOW  = 1'b1;

   typedef struct packed {
      logic            kind;
      logic [NS_W-1:0] elapsed_ns;
      logic            new_level;
   } req_payload_type;

   typedef struct packed {
      logic [AMP_W-1:0] sound_level;
      logic             bit_level;
      logic [TOG_W-1:0] toggles;
   } rsp_payload_type;

   typedef struct packed {
      logic            reg_index;
      logic [NS_W-1:0] wdata;
   } csr_payload_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CORR,
      ST_APPLY,
      ST_TOGGLE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic mul_stage;
      logic corr_stage;
      logic apply;
      logic toggle;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_level;
      logic ns_zero;
      logic wave_on;
      logic hpc_low;
   } status_type;

endpackage

FILE: design/bcs_chan_if.sv
interface bcs_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: design/bcs_datapath.sv
module bcs_datapath #(
   parameter int NS_PER_STEP = 88
) (
   input  logic                     clock,
   input  logic                     reset,
   input  bcs_pkg::req_payload_type req_payload,
   input  logic                     csr_we,
   input  bcs_pkg::csr_payload_type csr_payload,
   input  bcs_pkg::cmd_type         cmd,
   output bcs_pkg::status_type      status,
   output bcs_pkg::rsp_payload_type rsp_payload
);

   localparam int NS_W        = bcs_pkg::NS_W;
   localparam int AMP_W       = bcs_pkg::AMP_W;
   localparam int HPC_W       = bcs_pkg::HPC_W;
   localparam int TOG_W       = bcs_pkg::TOG_W;
   localparam int STEP_W      = $clog2(NS_PER_STEP + 1);
   localparam int RECIP_SHIFT = 26;
   localparam int RPROD_W     = NS_W + RECIP_SHIFT + 1;
   localparam int BPROD_W     = NS_W + STEP_W;
   localparam longint unsigned RECIP_VAL = (64'd1 << RECIP_SHIFT) / NS_PER_STEP;
   localparam logic [RECIP_SHIFT:0] RECIP = (RECIP_SHIFT + 1)'(RECIP_VAL);
   localparam logic [STEP_W-1:0]    STEP  = STEP_W'(NS_PER_STEP);
   localparam logic [AMP_W-1:0]     AMP_MAX = '1;

   logic [NS_W-1:0]         period_high_ff, period_high_in;
   logic [NS_W-1:0]         period_low_ff, period_low_in;
   logic [AMP_W-1:0]        amp_ff, amp_in;
   logic                    bit_ff, bit_in;
   logic signed [HPC_W-1:0] hpc_ff, hpc_in;
   logic [TOG_W-1:0]        tog_ff, tog_in;
   logic [NS_W-1:0]         div_ns_ff, div_ns_in;
   logic [NS_W-1:0]         quot_ff, quot_in;
   logic [BPROD_W-1:0]      back_ff, back_in;
   bcs_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [RPROD_W-1:0]      recip_prod;
   logic [BPROD_W-1:0]      remainder;
   logic [NS_W:0]           quot_fix;
   logic [NS_W:0]           amp_up;
   logic [AMP_W-1:0]        amp_slewed;
   logic                    new_bit;
   logic [NS_W-1:0]         part;
   logic signed [HPC_W-1:0] hpc_sum;
   logic signed [HPC_W-1:0] hpc_neg;
   logic signed [HPC_W-1:0] hpc_elapsed;

   // Quotient estimate by reciprocal multiply; it is low by at most one.
   always_comb begin
      recip_prod = RPROD_W'(div_ns_ff) * RPROD_W'(RECIP);
      quot_in    = cmd.mul_stage ? recip_prod[RECIP_SHIFT +: NS_W] : quot_ff;
      back_in    = cmd.corr_stage ? BPROD_W'(quot_ff) * BPROD_W'(STEP) : back_ff;
   end

   // Correct the quotient and move the amplitude toward the bit level.
   always_comb begin
      remainder = BPROD_W'(div_ns_ff) - back_ff;
      quot_fix  = (NS_W + 1)'(quot_ff) + (NS_W + 1)'(remainder >= BPROD_W'(STEP));
      amp_up    = (NS_W + 1)'(amp_ff) + quot_fix;
      if (bit_ff) begin
         amp_slewed = (amp_up > (NS_W + 1)'(AMP_MAX)) ? AMP_MAX : amp_up[AMP_W-1:0];
      end else begin
         amp_slewed = (quot_fix > (NS_W + 1)'(amp_ff)) ? '0 : amp_ff - quot_fix[AMP_W-1:0];
      end
   end

   // Half-period bookkeeping for one toggle.
   always_comb begin
      new_bit     = ~bit_ff;
      part        = new_bit ? period_high_ff : period_low_ff;
      hpc_sum     = hpc_ff + $signed(HPC_W'(part));
      hpc_neg     = -hpc_ff;
      hpc_elapsed = hpc_ff - $signed(HPC_W'(req_payload.elapsed_ns));
   end

   // Next values of the state registers.
   always_comb begin
      period_high_in = period_high_ff;
      period_low_in  = period_low_ff;
      amp_in         = amp_ff;
      bit_in         = bit_ff;
      hpc_in         = hpc_ff;
      tog_in         = tog_ff;
      div_ns_in      = div_ns_ff;
      rsp_in         = rsp_ff;
      if (csr_we) begin
         if (csr_payload.reg_index == bcs_pkg::REG_PERIOD_HIGH) begin
            period_high_in = csr_payload.wdata;
         end else begin
            period_low_in = csr_payload.wdata;
         end
      end
      if (cmd.load_item) begin
         if (req_payload.kind == bcs_pkg::KIND_LEVEL) begin
            bit_in = req_payload.new_level;
         end else begin
            div_ns_in = req_payload.elapsed_ns;
            if (status.wave_on) begin
               hpc_in = hpc_elapsed;
            end
         end
      end
      if (cmd.apply) begin
         amp_in = amp_slewed;
      end
      if (cmd.toggle) begin
         bit_in    = new_bit;
         tog_in    = tog_ff + TOG_W'(1);
         hpc_in    = hpc_sum;
         // Only the part of the half-period inside the interval slews.
         div_ns_in = (hpc_sum > 0) ? hpc_neg[NS_W-1:0] : part;
      end
      if (cmd.load_out) begin
         rsp_in.sound_level = amp_ff;
         rsp_in.bit_level   = bit_ff;
         rsp_in.toggles     = tog_ff;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         period_high_ff <= '0;
         period_low_ff  <= '0;
         amp_ff         <= '0;
         bit_ff         <= 1'b0;
         hpc_ff         <= '0;
         tog_ff         <= '0;
      end else begin
         period_high_ff <= period_high_in;
         period_low_ff  <= period_low_in;
         amp_ff         <= amp_in;
         bit_ff         <= bit_in;
         hpc_ff         <= hpc_in;
         tog_ff         <= tog_in;
      end
   end

   // Working and result registers.
   always_ff @(posedge clock) begin
      div_ns_ff <= div_ns_in;
      quot_ff   <= quot_in;
      back_ff   <= back_in;
      rsp_ff    <= rsp_in;
   end

   // Status toward the controller.
   always_comb begin
      status.is_level = (req_payload.kind == bcs_pkg::KIND_LEVEL);
      status.ns_zero  = (req_payload.elapsed_ns == '0);
      status.wave_on  = (period_high_ff != '0) && (period_low_ff != '0);
      status.hpc_low  = hpc_ff[HPC_W-1] || (hpc_ff == '0);
   end

   assign rsp_payload = rsp_ff;

   // A toggle is only issued while the wave runs and the half-period has run out.
   assert property (@(posedge clock) disable iff (reset)
      cmd.toggle |-> (status.wave_on && status.hpc_low))
      else $error("toggle issued with time left in the half-period");

   // Each toggle flips the bit and counts once.
   assert property (@(posedge clock) disable iff (reset)
      cmd.toggle |=> (bit_ff != $past(bit_ff)) && (tog_ff == $past(tog_ff) + TOG_W'(1)))
      else $error("toggle did not flip the bit or count");

   // The corrected quotient is never more than one above the estimate.
   assert property (@(posedge clock) disable iff (reset)
      cmd.apply |-> (remainder < BPROD_W'(2 * NS_PER_STEP)))
      else $error("reciprocal quotient estimate out of range");

endmodule

FILE: design/bcs_controller.sv
module bcs_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  bcs_pkg::status_type status,
   output bcs_pkg::cmd_type    cmd
);

   bcs_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (status.is_level || status.ns_zero) begin
                  state_in = bcs_pkg::ST_FINISH;
               end else begin
                  state_in = bcs_pkg::ST_MUL;
               end
            end
         end
         bcs_pkg::ST_MUL: begin
            state_in = bcs_pkg::ST_CORR;
         end
         bcs_pkg::ST_CORR: begin
            state_in = bcs_pkg::ST_APPLY;
         end
         bcs_pkg::ST_APPLY: begin
            if (status.wave_on && status.hpc_low) begin
               state_in = bcs_pkg::ST_TOGGLE;
            end else begin
               state_in = bcs_pkg::ST_FINISH;
            end
         end
         bcs_pkg::ST_TOGGLE: begin
            state_in = bcs_pkg::ST_MUL;
         end
         bcs_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = bcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bcs_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands and handshake outputs.
   always_comb begin
      cmd            = '0;
      req_ready      = 1'b0;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         bcs_pkg::ST_MUL: begin
            cmd.mul_stage = 1'b1;
         end
         bcs_pkg::ST_CORR: begin
            cmd.corr_stage = 1'b1;
         end
         bcs_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
         end
         bcs_pkg::ST_TOGGLE: begin
            cmd.toggle = 1'b1;
         end
         bcs_pkg::ST_FINISH: begin
            cmd.load_out = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // The output register holds a result until it is taken.
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A level write or an empty advance goes straight to the result.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcs_pkg::ST_IDLE && req_valid && (status.is_level || status.ns_zero))
      |=> state_ff == bcs_pkg::ST_FINISH)
      else $error("short transaction did not go to finish");

   // A finished result is not dropped while the output is still held.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcs_pkg::ST_FINISH && rsp_valid_ff && !rsp_ready)
      |=> state_ff == bcs_pkg::ST_FINISH)
      else $error("result overwrote a pending transaction");

   // Every slew step comes after the correction multiply.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bcs_pkg::ST_APPLY) |-> $past(state_ff) == bcs_pkg::ST_CORR)
      else $error("slew applied without a quotient");

endmodule

FILE: design/beeper_channel_with_slew_top.sv
// Channel   Direction  Payload                                  Handshake
// req_if    in         kind, elapsed_ns, new_level              valid/ready
// rsp_if    out        sound_level, bit_level, toggles          valid/ready
// csr_if    in         reg_index (0 high, 1 low period), wdata  valid/ready, always ready
//
// A level write or a zero-length advance goes straight from idle to the finish state.
// An advance passes the slew divider (a reciprocal multiply and a correction multiply)
// and the slew step, and again for each wave toggle inside the interval. A new request is
// taken only in idle, once the result is loaded into the output register.
// Reset is synchronous and clears the level, the bit, the counters and both periods.
// A stalled result waits in the output register while the next transaction is taken.
module beeper_channel_with_slew_top #(
   parameter int NS_PER_STEP = 88
) (
   input logic        clock,
   input logic        reset,
   bcs_chan_if.sink   req_if,
   bcs_chan_if.source rsp_if,
   bcs_chan_if.sink   csr_if
);

   bcs_pkg::cmd_type    cmd;
   bcs_pkg::status_type status;
   logic                csr_we;

   // Configuration writes are taken in any cycle.
   assign csr_if.ready = 1'b1;
   assign csr_we       = csr_if.valid;

   bcs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bcs_datapath #(
      .NS_PER_STEP (NS_PER_STEP)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_if.payload),
      .csr_we      (csr_we),
      .csr_payload (csr_if.payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_if.payload)
   );

endmodule

FILE: tb/bcs_checker.sv
module bcs_checker #(
   parameter int NS_PER_STEP = 88
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  bcs_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  bcs_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  bcs_pkg::csr_payload_type csr_payload,
   output int                       mismatch_count,
   output int                       outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS_W          = bcs_pkg::NS_W;
   localparam int AMP_W         = bcs_pkg::AMP_W;
   localparam int TOG_W         = bcs_pkg::TOG_W;
   localparam int FULL_SWING_NS = NS_PER_STEP * 256;
   localparam int AMP_MAX       = 255;

   // Private copy of the channel state and the period registers.
   logic [NS_W-1:0]  high_ns;
   logic [NS_W-1:0]  low_ns;
   int               amplitude;
   logic             wave_bit;
   int               half_left;
   logic [TOG_W-1:0] toggle_total;

   // Predicted responses, oldest first.
   bcs_pkg::rsp_payload_type expected_levels[$];

   // Moves the amplitude toward the current wave bit for the given stretch of time.
   function automatic void slew_amplitude(input int ns);
      int steps;
      steps = ns / NS_PER_STEP;
      if (wave_bit) begin
         if (ns > FULL_SWING_NS || amplitude + steps > AMP_MAX) begin
            amplitude = AMP_MAX;
         end else begin
            amplitude = amplitude + steps;
         end
      end else begin
         if (ns > FULL_SWING_NS || amplitude - steps < 0) begin
            amplitude = 0;
         end else begin
            amplitude = amplitude - steps;
         end
      end
   endfunction

   // Applies one request to the state and returns the response it produces.
   function automatic bcs_pkg::rsp_payload_type predict_level(
      input bcs_pkg::req_payload_type item);
      int                       part;
      bcs_pkg::rsp_payload_type result;
      if (item.kind == bcs_pkg::KIND_LEVEL) begin
         wave_bit = item.new_level;
      end else if (item.elapsed_ns != '0) begin
         slew_amplitude(int'(item.elapsed_ns));
         // The wave runs only while both half-periods are nonzero.
         if (high_ns != '0 && low_ns != '0) begin
            half_left = half_left - int'(item.elapsed_ns);
            while (half_left < 1) begin
               wave_bit     = ~wave_bit;
               toggle_total = toggle_total + TOG_W'(1);
               part         = wave_bit ? int'(high_ns) : int'(low_ns);
               half_left    = half_left + part;
               if (half_left > 0) begin
                  part = part - half_left;
               end
               slew_amplitude(part);
            end
         end
      end
      result.sound_level = amplitude[AMP_W-1:0];
      result.bit_level   = wave_bit;
      result.toggles     = toggle_total;
      return result;
   endfunction

   // Counts and reports one field that differs from its prediction.
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Observe transactions at each rising edge; responses are matched before new
   // requests are predicted, since no response can belong to a request of the same edge.
   always @(posedge clock) begin
      bcs_pkg::rsp_payload_type want;
      if (reset) begin
         high_ns      = '0;
         low_ns       = '0;
         amplitude    = 0;
         wave_bit     = 1'b0;
         half_left    = 0;
         toggle_total = '0;
         expected_levels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_payload.reg_index == bcs_pkg::REG_PERIOD_HIGH) begin
               high_ns = csr_payload.wdata;
            end else begin
               low_ns = csr_payload.wdata;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %0d %0d %0d",
                        $time, rsp_payload.sound_level, rsp_payload.bit_level,
                        rsp_payload.toggles);
               mismatch_count++;
            end else begin
               want = expected_levels.pop_front();
               check_field("sound_level", 32'(want.sound_level),
                           32'(rsp_payload.sound_level));
               check_field("bit_level", 32'(want.bit_level), 32'(rsp_payload.bit_level));
               check_field("toggles", want.toggles, rsp_payload.toggles);
            end
         end
         if (req_valid && req_ready) begin
            expected_levels.push_back(predict_level(req_payload));
         end
      end
      outstanding <= expected_levels.size();
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NS_W          = bcs_pkg::NS_W;
   localparam int STEP_NS       = 88;
   localparam int ITEM_TARGET   = 1900;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int IDLE_PERCENT  = 26;
   localparam logic [NS_W-1:0] NS_MAX = '1;

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   outstanding;

   // Traffic controls for the sender and the receiver.
   logic idle_on;
   logic hold_request;
   logic hold_done;
   int   hold_left;
   int   items_sent;

   // Periods currently programmed, used to bound the elapsed time of advances.
   logic [NS_W-1:0] high_ns;
   logic [NS_W-1:0] low_ns;

   bcs_chan_if #(.payload_type(bcs_pkg::req_payload_type)) req_ch ();
   bcs_chan_if #(.payload_type(bcs_pkg::rsp_payload_type)) rsp_ch ();
   bcs_chan_if #(.payload_type(bcs_pkg::csr_payload_type)) csr_ch ();

   beeper_channel_with_slew_top #(
      .NS_PER_STEP(STEP_NS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   bcs_checker #(
      .NS_PER_STEP(STEP_NS)
   ) level_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_payload    (req_ch.payload),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_payload    (rsp_ch.payload),
      .csr_valid      (csr_ch.valid),
      .csr_ready      (csr_ch.ready),
      .csr_payload    (csr_ch.payload),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #10 clock = ~clock;

   // Give up when the run takes far longer than any correct run could.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[beeper_channel_with_slew_top] ERROR");
      $finish;
   end

   // Response side: random back-pressure, and one long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= 0;
         hold_done    <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done    <= 1'b1;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on) begin
         rsp_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offers one request transaction, with a random gap beforehand when idling is on.
   task automatic send_item(input logic kind, input logic [NS_W-1:0] ns, input logic lvl);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= '{kind: kind, elapsed_ns: ns, new_level: lvl};
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Stops offering requests and waits until every predicted response has arrived.
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Programs both half-periods; the block must be idle.
   task automatic write_periods(input logic [NS_W-1:0] ph, input logic [NS_W-1:0] pl);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= '{reg_index: bcs_pkg::REG_PERIOD_HIGH, wdata: ph};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.payload <= '{reg_index: bcs_pkg::REG_PERIOD_LOW, wdata: pl};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      high_ns = ph;
      low_ns  = pl;
   endtask

   // Picks a half-period, weighted toward the extremes and short values.
   function automatic logic [NS_W-1:0] pick_period();
      unique case ($urandom_range(9))
         0:       return '0;
         1:       return NS_W'(1);
         2:       return NS_MAX;
         3, 4:    return NS_W'($urandom_range(64, 1));
         5, 6:    return NS_W'($urandom_range(2000, 1));
         default: return NS_W'($urandom_range(NS_MAX, 1));
      endcase
   endfunction

   // Random request; advances are bounded so that each one causes only a few toggles.
   task automatic send_random_item();
      int              bound;
      int              pick;
      logic [NS_W-1:0] ns;
      if (high_ns == '0 || low_ns == '0) begin
         bound = int'(NS_MAX);
      end else begin
         bound = 4 * (int'(high_ns) + int'(low_ns));
         if (bound > int'(NS_MAX)) begin
            bound = int'(NS_MAX);
         end
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
         ns = '0;
      end else if (pick < 14) begin
         ns = NS_W'(bound);
      end else if (pick < 45) begin
         ns = NS_W'($urandom_range((bound < 400) ? bound : 400));
      end else begin
         ns = NS_W'($urandom_range(bound, 1));
      end
      if ($urandom_range(99) < 20) begin
         send_item(bcs_pkg::KIND_LEVEL, NS_W'($urandom), 1'($urandom_range(1)));
      end else begin
         send_item(bcs_pkg::KIND_ADVANCE, ns, 1'($urandom_range(1)));
      end
   endtask

   initial begin
      int phase;
      int count;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.payload = '0;
      idle_on        = 1'b1;
      hold_request   = 1'b0;
      items_sent     = 0;
      high_ns        = '0;
      low_ns         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Wave disabled after reset: slew steps, full-swing jumps and saturation.
      send_item(bcs_pkg::KIND_LEVEL, '0, 1'b1);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(22528), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, '0, 1'b1);
      send_item(bcs_pkg::KIND_LEVEL, NS_MAX, 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(22529), 1'b0);
      send_item(bcs_pkg::KIND_LEVEL, '0, 1'b1);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(87), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(88), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(175), 1'b1);
      send_item(bcs_pkg::KIND_ADVANCE, NS_MAX, 1'b0);
      send_item(bcs_pkg::KIND_LEVEL, '0, 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(176), 1'b1);

      // Longest half-periods; the counter starts at zero, so the first advance toggles.
      drain();
      write_periods(NS_MAX, NS_MAX);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(1), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_MAX, 1'b0);
      send_item(bcs_pkg::KIND_LEVEL, NS_W'(16'h5a5a), 1'b1);
      send_item(bcs_pkg::KIND_ADVANCE, '0, 1'b0);

      // Shortest half-periods: the long advance runs out the old count, and the
      // following advances see one toggle for each nanosecond.
      drain();
      write_periods(NS_W'(1), NS_W'(1));
      send_item(bcs_pkg::KIND_ADVANCE, NS_MAX, 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(8), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(1), 1'b0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(5), 1'b0);
      send_item(bcs_pkg::KIND_LEVEL, '0, 1'b0);

      // One half-period zero: advances only slew and leave the counter alone.
      drain();
      write_periods('0, NS_W'(300));
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(1000), 1'b0);
      drain();
      write_periods(NS_W'(300), '0);
      send_item(bcs_pkg::KIND_ADVANCE, NS_W'(2000), 1'b0);

      // Random phases, each with its own period setting programmed while idle.
      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         drain();
         write_periods(pick_period(), pick_period());
         // Two phases run without idling; the second of them also holds off responses for a long time.
         idle_on <= !(phase == 2 || phase == 4);
         if (phase == 4) begin
            hold_request <= 1'b1;
         end
         count = $urandom_range(110, 40);
         repeat (count) send_random_item();
         phase++;
      end

      drain();
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("[beeper_channel_with_slew_top] OK");
      end else begin
         $display("[beeper_channel_with_slew_top] ERROR");
      end
      $finish;
   end

endmodule
